### src/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants for the running prefix average
// Widths of the sample, sum, count and divider paths, and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package rpa_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 17;
   localparam int SUM_W       = 32;
   localparam int NUM_W       = 34;   // 2*sum + count
   localparam int DEN_W       = 18;   // 2*count
   localparam int QUOT_W      = 16;   // mean never exceeds the largest sample
   localparam int STEP_W      = 4;    // counts QUOT_W divider iterations
   localparam int RSP_TDATA_W = 40;   // average + sample_count, padded to bytes
   localparam int RSP_PAD_W   = RSP_TDATA_W - SAMPLE_W - COUNT_W;

   localparam logic [COUNT_W-1:0] MAX_COUNT  = 17'd65536;
   localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(QUOT_W - 1);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic update;    // fold the accepted sample into sum and count
      logic load;      // set up numerator and denominator
      logic step;      // one restoring divide iteration
      logic capture;   // move the quotient into the output register
   } rpa_cmd_type;

endpackage

### src/running_prefix_average.sv
// ----------------------------------------------------------------------------
// running_prefix_average: cumulative moving average of a sample stream
// Each transfer on the req channel carries one unsigned 16-bit sample in
// req_tdata and a start flag in req_tuser; a set flag clears the running
// sum and count before the sample is added. Each sample yields exactly one
// transfer on the rsp channel: the mean of all samples since the last
// start, rounded half up, the number of samples in it, and an overflow
// flag in rsp_tuser when the count limit was already reached and the
// sample was dropped.
// One item is in work at a time: after the req transfer a setup step
// loads the restoring divider, which retires one of 16 quotient bits per
// cycle, and the hand-off then moves the result to the output register;
// only after the hand-off is a new item taken.
// The result waits in an output register, so the next sample is accepted
// and worked on while the receiver stalls; only the hand-off waits.
// Reset clears sum, count and the valid flag; the first sample starts a
// new average whatever its start flag.
// ----------------------------------------------------------------------------
module running_prefix_average (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rpa_pkg::SAMPLE_W-1:0]      req_tdata,   // [15:0] sample
   input  logic                              req_tuser,   // [0] start_req
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rpa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [15:0] average,
                                                          // [32:16] sample_count,
                                                          // [39:33] zero
   output logic                              rsp_tuser    // [0] overflow
);
   import rpa_pkg::*;

   rpa_cmd_type        cmd;
   logic [SAMPLE_W-1:0] average;
   logic [COUNT_W-1:0]  sample_count;

   // Controller
   rpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath
   rpa_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample       (req_tdata),
      .start_req    (req_tuser),
      .average      (average),
      .sample_count (sample_count),
      .overflow     (rsp_tuser)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, sample_count, average};

endmodule

### src/rpa_dpath.sv
// ----------------------------------------------------------------------------
// rpa_dpath: accumulator, restoring divider and output register
// Keeps the running sum and count, forms (2*sum+count)/(2*count) one
// quotient bit per cycle, and holds the finished result for the receiver.
// ----------------------------------------------------------------------------
module rpa_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  rpa_pkg::rpa_cmd_type           cmd,
   input  logic [rpa_pkg::SAMPLE_W-1:0]   sample,
   input  logic                           start_req,
   output logic [rpa_pkg::SAMPLE_W-1:0]   average,
   output logic [rpa_pkg::COUNT_W-1:0]    sample_count,
   output logic                           overflow
);
   import rpa_pkg::*;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [SUM_W-1:0]   sum_base;
   logic [COUNT_W-1:0] count_base;

   logic [NUM_W-1:0]   num;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]     trial;

   logic [SAMPLE_W-1:0] avg_ff;
   logic [COUNT_W-1:0]  cnt_out_ff;
   logic                ovf_out_ff;

   // Fold in the sample unless the count limit is reached
   always_comb begin
      sum_base   = start_req ? '0 : sum_ff;
      count_base = start_req ? '0 : count_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      if (cmd.update) begin
         if (count_base < MAX_COUNT) begin
            sum_in   = sum_base + SUM_W'(sample);
            count_in = count_base + COUNT_W'(1);
            ovf_in   = 1'b0;
         end else begin
            sum_in   = sum_base;
            count_in = count_base;
            ovf_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Restoring divider: remainder starts below the divisor, quotient fits 16 bits
   assign num   = {1'b0, sum_ff, 1'b0} + NUM_W'(count_ff);
   assign trial = {rem_ff, quo_ff[QUOT_W-1]} - {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (cmd.load) begin
         rem_in = num[NUM_W-1:QUOT_W];
         quo_in = num[QUOT_W-1:0];
         den_in = {count_ff, 1'b0};
      end else if (cmd.step) begin
         if (!trial[DEN_W]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DEN_W-2:0], quo_ff[QUOT_W-1]};
            quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   // Hold the finished result until the controller captures the next one
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         avg_ff     <= quo_ff;
         cnt_out_ff <= count_ff;
         ovf_out_ff <= ovf_ff;
      end
   end

   assign average      = avg_ff;
   assign sample_count = cnt_out_ff;
   assign overflow     = ovf_out_ff;

endmodule

### src/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl: sequencing controller
// Accepts one item, runs the divider for all quotient bits, and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module rpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output rpa_pkg::rpa_cmd_type  cmd
);
   import rpa_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      LOAD,
      DIVIDE,
      FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd         = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.update = 1'b1;
               state_in   = LOAD;
            end
         end
         LOAD: begin
            cmd.load = 1'b1;
            step_in  = LAST_STEP;
            state_in = DIVIDE;
         end
         DIVIDE: begin
            cmd.step = 1'b1;
            if (step_ff == '0) begin
               state_in = FINISH;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         FINISH: begin
            if (out_free) begin
               cmd.capture = 1'b1;
               state_in    = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      rsp_valid_in = cmd.capture ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Hold state, step counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
